FILE: rtl/rwc_pkg.sv
// shared types and constants for the replay window checker
package rwc_pkg;

  // window geometry
  localparam int WinDepth = 20;
  localparam int CntW     = $clog2(WinDepth + 1);
  localparam int SeqW     = 32;
  localparam int LenW     = 16;
  localparam int SkipW    = 8;
  localparam int StatW    = 3;
  localparam int KeptW    = 5;

  // configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // register reset values
  localparam logic [SkipW-1:0] SkipLimitRst = SkipW'(10);
  localparam logic [LenW-1:0]  MaxLenRst    = LenW'(256);

  // register indexes
  typedef enum logic {
    REG_SKIP_LIMIT = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_ACCEPT   = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_BELOW    = 3'd2,
    ST_SKIP     = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic ins;   // insert the pending sequence this cycle
    logic drop;  // window full, oldest entry leaves on insert
  } cell_ctl_t;

endpackage

FILE: rtl/rwc_req_if.sv
// request channel: sequence number and message length
interface rwc_req_if;
  import rwc_pkg::*;

  logic            valid;
  logic            ready;
  logic [SeqW-1:0] sequence_req;
  logic [LenW-1:0] message_length;

  modport source (output valid, output sequence_req, output message_length, input ready);
  modport sink   (input valid, input sequence_req, input message_length, output ready);
endinterface

FILE: rtl/rwc_rsp_if.sv
// response channel: status and number of kept sequences
interface rwc_rsp_if;
  import rwc_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [KeptW-1:0] kept_count;

  modport source (output valid, output status, output kept_count, input ready);
  modport sink   (input valid, input status, input kept_count, output ready);
endinterface

FILE: rtl/replay_window_checker_unit.sv
// top level of the anti-replay sequence window checker
//
//  channel   dir  payload                          handshake
//  req_i     in   sequence_req, message_length     valid / ready
//  rsp_o     out  status, kept_count               valid / ready
//  apb       in   skip_limit, max_message_length   psel / penable / pwrite
//
// a word is taken into a holding register, then checked against all cells at
// once and committed, one word per cycle while the response side keeps up.
// the commit waits only on the response register being free, so a stalled
// response keeps up to two words in flight (one in the holding register, one
// in the response register) and blocks further requests.
// reset empties the window (count to zero) and loads the register defaults.
module replay_window_checker_unit
  import rwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  rwc_req_if.sink          req_i,
  rwc_rsp_if.source        rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [SkipW-1:0] skip_limit;
  logic [LenW-1:0]  max_len;

  logic            pend_q, pend_d;
  logic [SeqW-1:0] seq_q;
  logic [LenW-1:0] len_q;
  logic [SeqW-1:0] newest_q, newest_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [StatW-1:0] rsp_stat_q;
  logic [KeptW-1:0] rsp_kept_q;

  logic            commit, req_fire;
  logic            too_long, below, skip_far, dup, nonempty;
  logic [SeqW:0]   skip_bound;
  status_e         status;
  cell_ctl_t       ctl;

  logic [SeqW-1:0] entry_w [WinDepth];
  logic [WinDepth-1:0] lt_w, eq_w;

  // configuration registers
  rwc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .skip_limit_o (skip_limit),
    .max_len_o    (max_len)
  );

  // request holding register and handshake
  assign commit      = pend_q & (~rsp_valid_q | rsp_o.ready);
  assign req_i.ready = ~pend_q | commit;
  assign req_fire    = req_i.valid & req_i.ready;

  always_comb begin
    pend_d = pend_q;
    if (req_fire) begin
      pend_d = 1'b1;
    end else if (commit) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      seq_q <= req_i.sequence_req;
      len_q <= req_i.message_length;
    end
  end

  // row of cells
  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    logic            prev_lt, next_lt;
    logic [SeqW-1:0] prev_entry, next_entry;
    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = seq_q;
    end else begin : g_mid_lo
      assign prev_lt    = lt_w[i-1];
      assign prev_entry = entry_w[i-1];
    end
    if (i == WinDepth - 1) begin : g_last
      assign next_lt    = 1'b0;
      assign next_entry = seq_q;
    end else begin : g_mid_hi
      assign next_lt    = lt_w[i+1];
      assign next_entry = entry_w[i+1];
    end
    rwc_cell u_cell (
      .clk_i,
      .ctl_i        (ctl),
      .valid_i      (CntW'(i) < count_q),
      .seq_i        (seq_q),
      .prev_lt_i    (prev_lt),
      .prev_entry_i (prev_entry),
      .next_lt_i    (next_lt),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[i]),
      .lt_o         (lt_w[i]),
      .eq_o         (eq_w[i])
    );
  end

  // checks in priority order
  assign nonempty   = (count_q != '0);
  assign skip_bound = {1'b0, newest_q} + (SeqW + 1)'(skip_limit);
  assign too_long   = (len_q > max_len);
  assign below      = nonempty & (seq_q < entry_w[0]);
  assign skip_far   = nonempty & ({1'b0, seq_q} > skip_bound);
  assign dup        = |eq_w;

  always_comb begin
    if (too_long) begin
      status = ST_TOO_LONG;
    end else if (below) begin
      status = ST_BELOW;
    end else if (skip_far) begin
      status = ST_SKIP;
    end else if (dup) begin
      status = ST_DUP;
    end else begin
      status = ST_ACCEPT;
    end
  end

  assign ctl.ins  = commit & (status == ST_ACCEPT);
  assign ctl.drop = (count_q == CntW'(WinDepth));

  // count and newest entry tracking
  always_comb begin
    count_d  = count_q;
    newest_d = newest_q;
    if (ctl.ins) begin
      if (!ctl.drop) begin
        count_d = count_q + CntW'(1);
      end
      if (!nonempty || (seq_q > newest_q)) begin
        newest_d = seq_q;
      end
    end
  end

  // response register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_stat_q <= status;
      rsp_kept_q <= KeptW'(count_d);
    end
    if (ctl.ins) begin
      newest_q <= newest_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_stat_q;
  assign rsp_o.kept_count = rsp_kept_q;

endmodule

FILE: rtl/rwc_cfg.sv
// apb register block for skip limit and maximum message length
module rwc_cfg
  import rwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [SkipW-1:0] skip_limit_o,
  output logic [LenW-1:0]  max_len_o
);

  logic [SkipW-1:0] skip_q, skip_d;
  logic [LenW-1:0]  maxlen_q, maxlen_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  // register write decode
  always_comb begin
    skip_d   = skip_q;
    maxlen_d = maxlen_q;
    if (wr_en) begin
      case (idx)
        REG_SKIP_LIMIT: skip_d   = pwdata[SkipW-1:0];
        REG_MAX_LENGTH: maxlen_d = pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SKIP_LIMIT: prdata = DataW'(skip_q);
      REG_MAX_LENGTH: prdata = DataW'(maxlen_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= SkipLimitRst;
      maxlen_q <= MaxLenRst;
    end else begin
      skip_q   <= skip_d;
      maxlen_q <= maxlen_d;
    end
  end

  assign skip_limit_o = skip_q;
  assign max_len_o    = maxlen_q;

endmodule

FILE: rtl/rwc_cell.sv
// one window cell: holds a kept sequence, compares and shifts with its neighbors
module rwc_cell
  import rwc_pkg::*;
(
  input  logic            clk_i,
  input  cell_ctl_t       ctl_i,
  input  logic            valid_i,
  input  logic [SeqW-1:0] seq_i,
  input  logic            prev_lt_i,
  input  logic [SeqW-1:0] prev_entry_i,
  input  logic            next_lt_i,
  input  logic [SeqW-1:0] next_entry_i,
  output logic [SeqW-1:0] entry_o,
  output logic            lt_o,
  output logic            eq_o
);

  logic [SeqW-1:0] entry_q, entry_d;

  // compare against the broadcast sequence
  assign lt_o = valid_i & (entry_q < seq_i);
  assign eq_o = valid_i & (entry_q == seq_i);

  // sorted insert: shift up without drop, shift down toward the oldest with drop
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (!ctl_i.drop) begin
        if (!lt_o) begin
          entry_d = prev_lt_i ? seq_i : prev_entry_i;
        end
      end else if (lt_o) begin
        entry_d = next_lt_i ? next_entry_i : seq_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: tb/tb_replay_window_checker_unit.sv
// testbench for the replay window checker: random and directed posts checked against a window model
`timescale 1ns / 100ps

module tb_replay_window_checker_unit;
  import rwc_pkg::*;

  localparam logic [SeqW-1:0] MaxSeq  = '1;
  localparam logic [LenW-1:0] MaxLen  = '1;
  // the window lives near the top of the sequence space so that the
  // newest-plus-skip sum can pass the 32-bit range late in the run
  localparam logic [SeqW-1:0] WinBase = 32'hFFFF_C000;

  // one expected response word
  typedef struct packed {
    status_e          status;
    logic [KeptW-1:0] kept_count;
  } verdict_t;

  // window model plus queue of expected responses
  class replay_scoreboard;
    logic [SeqW-1:0]  win [WinDepth+1];
    int unsigned      held;
    logic [SkipW-1:0] skip;
    logic [LenW-1:0]  max_len;
    verdict_t         due_q [$];
    int unsigned      errors;

    function new();
      held    = 0;
      skip    = SkipLimitRst;
      max_len = MaxLenRst;
      errors  = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] val);
      case (idx)
        REG_SKIP_LIMIT: skip = val[SkipW-1:0];
        REG_MAX_LENGTH: max_len = val[LenW-1:0];
        default: ;
      endcase
    endfunction

    // run the checks in order and update the window on acceptance
    function void note_word(logic [SeqW-1:0] seq, logic [LenW-1:0] len);
      verdict_t    v;
      int unsigned pos;
      int unsigned i;
      logic [SeqW:0] top;
      if (len > max_len) begin
        v.status = ST_TOO_LONG;
      end else if (held > 0 && seq < win[0]) begin
        v.status = ST_BELOW;
      end else begin
        top = (held > 0) ? ({1'b0, win[held-1]} + {{(SeqW+1-SkipW){1'b0}}, skip}) : '1;
        if (held > 0 && {1'b0, seq} > top) begin
          v.status = ST_SKIP;
        end else begin
          pos = 0;
          while (pos < held && win[pos] < seq) pos++;
          if (pos < held && win[pos] == seq) begin
            v.status = ST_DUP;
          end else begin
            for (i = held; i > pos; i--) win[i] = win[i-1];
            win[pos] = seq;
            held++;
            // oldest entry leaves once the window overflows
            if (held > WinDepth) begin
              for (i = 0; i + 1 < held; i++) win[i] = win[i+1];
              held--;
            end
            v.status = ST_ACCEPT;
          end
        end
      end
      v.kept_count = KeptW'(held);
      due_q.push_back(v);
    endfunction

    function void check_word(logic [StatW-1:0] st, logic [KeptW-1:0] kc);
      verdict_t v;
      if (due_q.size() == 0) begin
        $error("unexpected response: status %0d kept_count %0d", st, kc);
        errors++;
        return;
      end
      v = due_q.pop_front();
      if (st !== v.status) begin
        $error("status: expected %s, got %0d", v.status.name(), st);
        errors++;
      end
      if (kc !== v.kept_count) begin
        $error("kept_count: expected %0d, got %0d", v.kept_count, kc);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  bit               calm;
  logic [SeqW-1:0]  seq_ceiling;

  rwc_req_if req ();
  rwc_rsp_if rsp ();

  replay_scoreboard sb = new();

  replay_window_checker_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // response side back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_word(rsp.status, rsp.kept_count);
  end

  // offer one word, note it once taken
  task automatic send_word(input logic [SeqW-1:0] seq, input logic [LenW-1:0] len);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid          <= 1'b1;
    req.sequence_req   <= seq;
    req.message_length <= len;
    do @(posedge clk_i); while (!req.ready);
    sb.note_word(seq, len);
  endtask

  // stop sending and wait for every outstanding response
  task automatic settle();
    req.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup then access phase, then back to idle
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // sequence aimed at the live window: advances, boundary hits, gap fills,
  // rejects above and below, and some pure noise
  function automatic logic [SeqW-1:0] pick_seq();
    logic [SeqW-1:0] oldest;
    logic [SeqW-1:0] newest;
    logic [SeqW:0]   cand;
    int unsigned     r;
    if (sb.held == 0) return $urandom;
    oldest = sb.win[0];
    newest = sb.win[sb.held-1];
    r = $urandom_range(0, 99);
    if (r < 40) begin
      cand = {1'b0, newest} + (SeqW+1)'($urandom_range(1, 3));
    end else if (r < 48) begin
      cand = {1'b0, newest} + (SeqW+1)'(sb.skip);
    end else if (r < 56) begin
      cand = {1'b0, newest} + (SeqW+1)'(sb.skip) + 1;
      if (cand > {1'b0, MaxSeq}) return $urandom;
      return $urandom_range(cand[SeqW-1:0], MaxSeq);
    end else if (r < 70) begin
      cand = {1'b0, 32'($urandom_range(oldest, newest))};
    end else if (r < 86) begin
      if (oldest == 0) return $urandom;
      return $urandom_range(0, oldest - 1);
    end else begin
      return $urandom;
    end
    // keep the window from drifting to the top before the final phase
    if (cand > {1'b0, seq_ceiling}) cand = {1'b0, 32'($urandom_range(oldest, newest))};
    return cand[SeqW-1:0];
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return sb.max_len;
    if (r < 14 && sb.max_len != MaxLen) return sb.max_len + 1'b1;
    if (r < 88) return $urandom_range(0, sb.max_len);
    return $urandom_range(0, MaxLen);
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      calm = ((i / 40) % 4 == 3);
      send_word(pick_seq(), pick_len());
      if ($urandom_range(0, 99) == 0) settle();
    end
    calm = 1'b0;
  endtask

  // step the window up by the skip limit until it holds the largest sequence
  task automatic climb_to_top();
    logic [SeqW-1:0] newest;
    newest = sb.win[sb.held-1];
    while (newest != MaxSeq) begin
      if (MaxSeq - newest > sb.skip) send_word(newest + sb.skip, pick_len());
      else send_word(MaxSeq, pick_len());
      newest = sb.win[sb.held-1];
    end
  endtask

  // stimulus
  initial begin
    rst_ni             = 1'b0;
    calm               = 1'b0;
    seq_ceiling        = 32'hFFFF_F000;
    req.valid          <= 1'b0;
    req.sequence_req   <= '0;
    req.message_length <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed posts with the reset register values
    send_word(WinBase, MaxLenRst + 1'b1);
    send_word(WinBase, '0);
    send_word(WinBase, MaxLenRst);
    send_word(WinBase - 1, '0);
    send_word('0, '0);
    send_word(WinBase + 10, '0);
    send_word(WinBase + 21, '0);
    send_word(MaxSeq, MaxLen);
    send_word(MaxSeq, '0);
    send_word(WinBase + 5, 16'd1);
    send_word(WinBase + 5, 16'd2);
    send_word(WinBase + 20, MaxLenRst);
    send_word(WinBase + 3, '0);

    // widest limits
    settle();
    write_reg(REG_SKIP_LIMIT, 32'd255);
    write_reg(REG_MAX_LENGTH, 32'(MaxLen));
    run_random(250);

    // tightest limits
    settle();
    write_reg(REG_SKIP_LIMIT, 32'd0);
    write_reg(REG_MAX_LENGTH, 32'd0);
    run_random(80);

    // random limits
    repeat (3) begin
      settle();
      write_reg(REG_SKIP_LIMIT, $urandom_range(0, 255));
      write_reg(REG_MAX_LENGTH, $urandom_range(0, 65535));
      run_random(120);
    end

    // top of the sequence space, where newest plus skip passes 32 bits
    settle();
    write_reg(REG_SKIP_LIMIT, 32'd255);
    write_reg(REG_MAX_LENGTH, 32'(MaxLen));
    seq_ceiling = MaxSeq;
    climb_to_top();
    run_random(120);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rwc_pkg.sv
rtl/rwc_req_if.sv
rtl/rwc_rsp_if.sv
rtl/rwc_cfg.sv
rtl/rwc_cell.sv
rtl/replay_window_checker_unit.sv
tb/tb_replay_window_checker_unit.sv
